>>> hw/rtl/mstc_pkg.sv
package mstc_pkg;

  localparam int NUM_TABLES = 512;
  localparam int TBL_AW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

  // PRESENT S-box, entry i in bits 4i+3:4i
  localparam logic [63:0] SBOX_PACKED = 64'h2174_8FE3_DA09_B65C;

  typedef logic [TBL_AW-1:0] tbl_addr_t;

  typedef enum logic {
    OP_PRECOMPUTE = 1'b0,
    OP_EVALUATE   = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [8:0]  table_index;
    logic [3:0]  share_zero;
    logic [3:0]  share_one;
    logic [3:0]  share_two;
    logic [3:0]  pre_share_a;
    logic [3:0]  pre_share_b;
    logic [1:0]  rand_v;
    logic [1:0]  rand_w;
    logic [7:0]  rand_r;
    logic [11:0] rand_gamma;
    logic [15:0] rand_y2;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_share_zero;
    logic [3:0] out_share_one;
    logic [3:0] out_share_two;
  } out_item_t;

  // One stored table set; pre_share holds share a in 3:0, share b in 7:4
  typedef struct packed {
    logic [15:0] tab;
    logic [7:0]  r;
    logic [1:0]  w;
    logic [11:0] gamma;
    logic [7:0]  pre_share;
  } entry_t;

  typedef struct packed {
    logic [3:0]  share_zero;
    logic [3:0]  share_one;
    logic [3:0]  share_two;
    logic [1:0]  v_s;
    logic [15:0] y2;
    entry_t      entry;
  } eval_req_t;

  function automatic logic [3:0] sb(input logic [1:0] hi, input logic [1:0] lo);
    return SBOX_PACKED[{hi, lo, 2'b00} +: 4];
  endfunction

  function automatic logic [1:0] rval(input logic [7:0] rr, input logic [1:0] k);
    return rr[{k, 1'b0} +: 2];
  endfunction

  // gamma[2] plus gamma[i] for each set bit i of the index
  function automatic logic [3:0] mask_sum(input logic [1:0] idx, input logic [11:0] g);
    logic [3:0] acc;
    acc = g[11:8];
    if (idx[0]) acc = acc ^ g[3:0];
    if (idx[1]) acc = acc ^ g[7:4];
    return acc;
  endfunction

  function automatic logic [15:0] build_table(
    input logic [3:0]  pa,
    input logic [3:0]  pb,
    input logic [1:0]  v,
    input logic [1:0]  w,
    input logic [7:0]  rr,
    input logic [11:0] g
  );
    logic [15:0] tab;
    logic [1:0]  sh;
    logic [1:0]  b;
    logic [3:0]  acc;
    tab = '0;
    sh = pa[3:2] ^ v ^ pb[3:2];
    for (int a = 0; a < 4; a++) begin
      b = 2'(a) ^ sh;
      acc = mask_sum(b, g);
      for (int k = 0; k < 4; k++) begin
        acc = acc ^ sb(2'(a) ^ rval(rr, 2'(k) ^ w) ^ v, pa[1:0] ^ 2'(k));
      end
      tab[{b, 2'b00} +: 4] = acc;
    end
    return tab;
  endfunction

endpackage

>>> hw/rtl/mstc_store.sv
module mstc_store import mstc_pkg::*; (
  input  logic      clk,
  input  logic      wr_en,
  input  tbl_addr_t wr_addr,
  input  entry_t    wr_data,
  input  logic      rd_en,
  input  tbl_addr_t rd_addr,
  output entry_t    rd_data
);

  entry_t mem_r [NUM_TABLES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // pass a same-edge write straight through
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/mstc_eval.sv
module mstc_eval import mstc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  output logic      req_ready,
  input  eval_req_t req,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef struct packed {
    logic [15:0] tab;
    logic [7:0]  rr;
    logic [11:0] g;
    logic [15:0] y2;
    logic [1:0]  hi3;
    logic [1:0]  lo3;
    logic [1:0]  it;
    logic [1:0]  sh;
    logic [1:0]  hi_a;
    logic [1:0]  hi_b;
    logic [1:0]  vs;
    logic [1:0]  m0;
  } s2_t;

  typedef struct packed {
    logic [15:0] t2;
    logic [3:0]  out0;
    logic [3:0]  y2sel;
    logic [1:0]  vs;
  } s3_t;

  s2_t       s2_r, s2_nxt;
  s3_t       s3_r, s3_nxt;
  out_item_t out_r, out_nxt;
  logic      s2_v_r, s3_v_r, out_v_r;
  logic      s2_rdy, s3_rdy, out_rdy;

  assign out_rdy   = !out_v_r || !out_stall;
  assign s3_rdy    = !s3_v_r || out_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign req_ready = s2_rdy;

  // unmask the input and derive indexes
  always_comb begin
    logic [3:0] pa;
    logic [3:0] pb;
    logic [3:0] x3;
    pa = req.entry.pre_share[3:0];
    pb = req.entry.pre_share[7:4];
    x3 = req.share_zero ^ req.share_one ^ req.share_two ^ pa ^ pb;
    s2_nxt.tab  = req.entry.tab;
    s2_nxt.rr   = req.entry.r;
    s2_nxt.g    = req.entry.gamma;
    s2_nxt.y2   = req.y2;
    s2_nxt.hi3  = x3[3:2];
    s2_nxt.lo3  = x3[1:0];
    s2_nxt.it   = pa[1:0] ^ x3[1:0] ^ req.entry.w;
    s2_nxt.sh   = pa[1:0] ^ req.v_s ^ pb[1:0];
    s2_nxt.hi_a = pa[3:2];
    s2_nxt.hi_b = pb[3:2];
    s2_nxt.vs   = req.v_s;
    s2_nxt.m0   = x3[3:2] ^ rval(req.entry.r, pb[1:0] ^ x3[1:0] ^ req.entry.w);
  end

  // unpack and re-mask all four table entries
  always_comb begin
    logic [3:0][1:0] ra;
    logic [1:0]      b;
    logic [3:0]      acc;
    for (int a = 0; a < 4; a++) begin
      ra[a] = rval(s2_r.rr, s2_r.it ^ 2'(a));
    end
    s3_nxt.t2 = '0;
    for (int a = 0; a < 4; a++) begin
      b = 2'(a) ^ s2_r.sh;
      acc = s2_r.tab[{s2_r.hi3 ^ ra[a], 2'b00} +: 4] ^ s2_r.y2[{b, 2'b00} +: 4];
      for (int k = 0; k < 4; k++) begin
        if (k != a) begin
          acc = acc ^ sb(s2_r.hi3 ^ ra[a] ^ s2_r.hi_a ^ ra[k] ^ s2_r.hi_b,
                         s2_r.lo3 ^ 2'(k));
        end
      end
      s3_nxt.t2[{b, 2'b00} +: 4] = acc;
    end
    s3_nxt.out0  = mask_sum(s2_r.m0, s2_r.g);
    s3_nxt.y2sel = s2_r.y2[{s2_r.vs, 2'b00} +: 4];
    s3_nxt.vs    = s2_r.vs;
  end

  always_comb begin
    out_nxt.out_share_zero = s3_r.out0;
    out_nxt.out_share_one  = s3_r.y2sel;
    out_nxt.out_share_two  = s3_r.t2[{s3_r.vs, 2'b00} +: 4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_rdy) s2_v_r <= req_valid;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (out_rdy) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && s2_rdy) s2_r <= s2_nxt;
    if (s2_v_r && s3_rdy) s3_r <= s3_nxt;
    if (s3_v_r && out_rdy) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

>>> hw/rtl/masked_sbox_table_compression_top.sv
// Second-order masked PRESENT S-box with compressed tables.
// Input channel in_valid/in_stall/in_item carries two kinds of item. A
// precompute item builds the packed four-nibble table for its index from
// the random fields and stores it with those randoms; it gives no result.
// An evaluate item reads the stored set for its index and gives one result
// item (three output shares) on out_valid/out_stall/out_item.
// An evaluate passes from the first stage through the two eval stages into
// the output register. Throughput is one item per cycle of either kind while
// out_stall is low; the table store has one write and one read port, and a
// precompute stores its set at the edge it leaves the first stage, so an
// evaluate right behind it on the same index already sees it.
// Stall: each stage holds its item while the one after it is full and
// stalled; empty stages keep filling, so in_stall rises only when every
// stage holds an item and out_stall is high.
// Reset: clears all valid bits. The table store is not cleared; evaluating
// an index that was never precomputed gives undefined shares.
module masked_sbox_table_compression_top import mstc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      s1_v_r;
  in_item_t  s1_item_r;
  logic      s1_inrange_r;
  logic      s1_is_eval;
  logic      s1_leave;
  logic      s1_rdy;
  logic      in_accept;
  logic      in_inrange;
  logic      wr_en;
  tbl_addr_t wr_addr;
  tbl_addr_t rd_addr;
  entry_t    wr_data;
  entry_t    rd_data;
  eval_req_t eval_req;
  logic      eval_valid;
  logic      eval_ready;

  assign in_inrange = 32'(in_item.table_index) < 32'(NUM_TABLES);
  assign s1_is_eval = (s1_item_r.opcode == OP_EVALUATE);
  // precompute leaves at once; evaluate waits for the eval pipe
  assign s1_leave   = s1_v_r && (!s1_is_eval || eval_ready);
  assign s1_rdy     = !s1_v_r || s1_leave;
  assign in_stall   = !s1_rdy;
  assign in_accept  = in_valid && s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r    <= in_item;
      s1_inrange_r <= in_inrange;
    end
  end

  always_comb begin
    wr_data.tab = build_table(s1_item_r.pre_share_a, s1_item_r.pre_share_b,
                              s1_item_r.rand_v, s1_item_r.rand_w,
                              s1_item_r.rand_r, s1_item_r.rand_gamma);
    wr_data.r         = s1_item_r.rand_r;
    wr_data.w         = s1_item_r.rand_w;
    wr_data.gamma     = s1_item_r.rand_gamma;
    wr_data.pre_share = {s1_item_r.pre_share_b, s1_item_r.pre_share_a};
  end

  assign wr_en   = s1_v_r && !s1_is_eval && s1_inrange_r;
  assign wr_addr = TBL_AW'(s1_item_r.table_index);
  assign rd_addr = TBL_AW'(in_item.table_index);

  mstc_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    eval_req.share_zero = s1_item_r.share_zero;
    eval_req.share_one  = s1_item_r.share_one;
    eval_req.share_two  = s1_item_r.share_two;
    eval_req.v_s        = s1_item_r.rand_v;
    eval_req.y2         = s1_item_r.rand_y2;
    // an index past the store reads as zeros
    eval_req.entry      = s1_inrange_r ? rd_data : '0;
  end

  assign eval_valid = s1_v_r && s1_is_eval;

  mstc_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (eval_valid),
    .req_ready (eval_ready),
    .req       (eval_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_no_stall_without_backpressure: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall
  ) else $error("input stalled while output is free");

  a_eval_latency: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.opcode == OP_EVALUATE)
      ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid
  ) else $error("evaluate item did not reach the output in time");

  a_store_forward: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_accept && wr_en && (wr_addr == rd_addr)) |=> (rd_data == $past(wr_data))
  ) else $error("same-index precompute not forwarded to evaluate");

endmodule
